// ===== src/windowed_tone_fsk_dpsk_modulator_assert.svh =====
// assertion macros for the windowed tone modulator
`ifndef WINDOWED_TONE_FSK_DPSK_MODULATOR_ASSERT_SVH
`define WINDOWED_TONE_FSK_DPSK_MODULATOR_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define WTFDM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequence in the same cycle
`define WTFDM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the next cycle
`define WTFDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wtfdm_pkg.sv =====
// shared types, constants and constant tables of the windowed tone modulator
package wtfdm_pkg;

	localparam int SAMPLES_PER_SYMBOL = 64;
	localparam int SINE_TABLE_BITS    = 10;

	localparam int CNT_W      = $clog2(SAMPLES_PER_SYMBOL);
	localparam int QSIZE      = 1 << (SINE_TABLE_BITS - 2);
	localparam int ADDR_W     = SINE_TABLE_BITS - 1;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int CFG_IDX_W  = 3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MODULATION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TONE_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_OFFSET   = 3'd4;

	localparam logic [15:0] NORM_GAIN_RESET = 16'd16384;

	// hamming window 0.54 / 0.46 in q15
	localparam logic signed [63:0] WIN_A = 64'sd17695;
	localparam logic signed [63:0] WIN_B = 64'sd15073;

	// odd polynomial for sin(pi/2 * u), unsigned q30
	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	typedef enum logic [1:0] {
		MODE_DATA   = 2'd0,
		MODE_ALT    = 2'd1,
		MODE_STEADY = 2'd2
	} sym_mode_t;

	// one classified symbol in the queue
	typedef struct packed {
		logic fsk;
		logic tone_low;
		logic clear_phase;
		logic psk_bit;
	} sym_t;

	typedef struct packed {
		logic               modulation;
		logic [31:0]        carrier_step;
		logic [31:0]        low_tone_step;
		logic [15:0]        norm_gain;
		logic signed [15:0] norm_offset;
	} cfg_t;

	typedef struct packed {
		logic             emit;
		logic             busy;
		logic [CNT_W-1:0] count;
	} back_stat_t;

	typedef logic [QSIZE:0][15:0]                qsine_tab_t;
	typedef logic [SAMPLES_PER_SYMBOL-1:0][15:0] win_tab_t;

	// quarter wave entry k, evaluated at elaboration only
	function automatic logic [15:0] qsine_f(input int unsigned k);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] p;
		logic [63:0] s;
		u  = 64'(k) << (32 - SINE_TABLE_BITS);
		u2 = (u * u) >> 30;
		p  = C9;
		p  = C7 - ((u2 * p) >> 30);
		p  = C5 - ((u2 * p) >> 30);
		p  = C3 - ((u2 * p) >> 30);
		p  = C1 - ((u2 * p) >> 30);
		s  = (u * p) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[15:0];
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t t;
		for (int i = 0; i <= QSIZE; i++) begin
			t[i] = qsine_f(i);
		end
		return t;
	endfunction

	localparam qsine_tab_t QSINE_TAB = build_qsine();

	// q15 sine from the top phase bits, quadrants by symmetry
	function automatic logic signed [15:0] sine_f(input logic [31:0] ph);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-3:0] r;
		logic [ADDR_W-1:0]          a;
		logic [15:0]                m;
		idx  = ph[31 -: SINE_TABLE_BITS];
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		r    = idx[SINE_TABLE_BITS-3:0];
		a    = quad[0] ? (ADDR_W'(QSIZE) - ADDR_W'(r)) : ADDR_W'(r);
		m    = QSINE_TAB[a];
		return quad[1] ? $signed(-m) : $signed(m);
	endfunction

	// window entry i, evaluated at elaboration only
	function automatic logic [15:0] window_f(input int unsigned i);
		logic [63:0]        num;
		logic [31:0]        ph;
		logic signed [15:0] c;
		logic signed [63:0] cl;
		logic signed [63:0] t;
		logic signed [63:0] w;
		num = 64'(i) << 32;
		ph  = 32'(num / 64'(SAMPLES_PER_SYMBOL - 1));
		c   = sine_f(ph + 32'h4000_0000);
		cl  = 64'(c);
		t   = (WIN_B * cl + 64'sd16384) >>> 15;
		w   = WIN_A - t;
		if (w > 64'sd32767) begin
			w = 64'sd32767;
		end
		return w[15:0];
	endfunction

	function automatic win_tab_t build_win();
		win_tab_t t;
		for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
			t[i] = window_f(i);
		end
		return t;
	endfunction

	localparam win_tab_t WIN_TAB = build_win();

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

// ===== src/windowed_tone_fsk_dpsk_modulator.sv =====
// top level of the hamming windowed fsk / differential bpsk tone modulator
//
//  channel | direction | handshake        | payload
//  s_*     | in        | s_tvalid/s_tready| symbol: bit, kind, start of record
//  m_*     | out       | m_tvalid/m_tready| q1.15 sample, last of symbol
//  cfg_*   | in        | cfg_valid/ready  | register index and write data
//
//  each symbol gives SAMPLES_PER_SYMBOL samples, one per cycle from the sample
//  generator while the output is not held back
//  after the symbol is taken, its first sample passes the queue, generator
//  load, table lookup, window multiply, gain multiply and output reg
//  a two entry queue lets the input side take the next symbols while one plays
//  output backpressure freezes the whole sample pipeline, nothing is dropped
//  reset clears the phase accumulator, phase bit and counters, registers to reset values
module windowed_tone_fsk_dpsk_modulator (
	input  logic        clk,
	input  logic        arst_n,
	// symbol items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [0] bit_value, [7:1] zero
	input  logic [2:0]  s_tuser,    // [1:0] mode, [2] start_of_record
	// sample items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] sample
	output logic        m_tlast,    // last_of_symbol
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import wtfdm_pkg::*;

`include "windowed_tone_fsk_dpsk_modulator_assert.svh"

	cfg_t             cfg_q;
	logic             q_push;
	sym_t             q_data;
	logic             q_pop;
	sym_t             q_head;
	logic             q_full;
	logic             q_nempty;
	logic [LVL_W-1:0] q_level;
	back_stat_t       bstat;
	logic             last_emit;

	// register file, to be written only while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulation    <= 1'b0;
			cfg_q.carrier_step  <= '0;
			cfg_q.low_tone_step <= '0;
			cfg_q.norm_gain     <= NORM_GAIN_RESET;
			cfg_q.norm_offset   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULATION:    cfg_q.modulation    <= cfg_data[0];
				REG_CARRIER_STEP:  cfg_q.carrier_step  <= cfg_data;
				REG_LOW_TONE_STEP: cfg_q.low_tone_step <= cfg_data;
				REG_NORM_GAIN:     cfg_q.norm_gain     <= cfg_data[15:0];
				REG_NORM_OFFSET:   cfg_q.norm_offset   <= $signed(cfg_data[15:0]);
				default:           ; // unmapped index, write ignored
			endcase
		end
	end

	// front: takes symbols, keeps the differential phase bit
	wtfdm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.bit_value       (s_tdata[0]),
		.mode            (s_tuser[1:0]),
		.start_of_record (s_tuser[2]),
		.modulation      (cfg_q.modulation),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (q_data)
	);

	// queue of classified symbols
	wtfdm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.nempty    (q_nempty),
		.level     (q_level)
	);

	// back: phase, table lookup, window, gain, output register
	wtfdm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_nempty (q_nempty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.stat     (bstat)
	);

	// last sample of a symbol leaves the generator
	assign last_emit = bstat.emit && bstat.count == CNT_W'(SAMPLES_PER_SYMBOL - 1);

	// queue level stays within its depth
	`WTFDM_ASSERT_ALWAYS(a_q_level, q_level <= LVL_W'(FIFO_DEPTH), "queue overflow")
	// no new sample is generated while the output is held
	`WTFDM_ASSERT_SAME(a_stall_freeze, m_tvalid && !m_tready, !bstat.emit, "emit during stall")
	// sample counter wraps after the last sample of a symbol
	`WTFDM_ASSERT_NEXT(a_count_wrap, last_emit, bstat.count == '0, "count wrap")

endmodule

// ===== src/wtfdm_front.sv =====
// input side: accepts symbols and resolves the differential phase bit
module wtfdm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                bit_value,
	input  logic [1:0]          mode,
	input  logic                start_of_record,
	input  logic                modulation,
	input  logic                q_full,
	output logic                q_push,
	output wtfdm_pkg::sym_t     q_data
);
	import wtfdm_pkg::*;

	logic psk_q;
	logic pb_base;
	logic pb;

	always_comb begin
		s_tready = !q_full;
		q_push   = s_tvalid && !q_full;
		pb_base  = start_of_record ? 1'b0 : psk_q;
		pb       = pb_base;
		if (modulation) begin
			unique case (sym_mode_t'(mode))
				MODE_DATA:   pb = pb_base ^ bit_value;
				MODE_ALT:    pb = ~pb_base;
				MODE_STEADY: pb = pb_base;
				default:     pb = pb_base;
			endcase
		end
		q_data.fsk         = !modulation;
		q_data.tone_low    = bit_value;
		q_data.clear_phase = start_of_record;
		q_data.psk_bit     = pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psk_q <= 1'b0;
		end else if (q_push) begin
			psk_q <= pb;
		end
	end

endmodule

// ===== src/wtfdm_fifo.sv =====
// short symbol queue between front and back
module wtfdm_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  wtfdm_pkg::sym_t         push_data,
	input  logic                    pop,
	output wtfdm_pkg::sym_t         head,
	output logic                    full,
	output logic                    nempty,
	output logic [wtfdm_pkg::LVL_W-1:0] level
);
	import wtfdm_pkg::*;

	sym_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign full   = level_q == LVL_W'(FIFO_DEPTH);
	assign nempty = level_q != '0;
	assign level  = level_q;
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/wtfdm_back.sv =====
// output side: sample generator and windowed tone datapath
module wtfdm_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wtfdm_pkg::cfg_t         cfg,
	input  logic                    q_nempty,
	input  wtfdm_pkg::sym_t         q_head,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             m_tdata,
	output logic                    m_tlast,
	output wtfdm_pkg::back_stat_t   stat
);
	import wtfdm_pkg::*;

	// generator
	sym_t             cur_q;
	logic             cur_vld_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      tone_q;
	logic [31:0]      acc_q;

	logic             adv;
	logic             emit;
	logic             last_smp;
	logic [31:0]      step;
	logic [31:0]      ph;
	logic [31:0]      acc_adv;

	// datapath
	logic               vld_s1, vld_s2, vld_s3, out_vld_q;
	logic               fsk_s1, fsk_s2, fsk_s3;
	logic               last_s1, last_s2, last_s3, last_q;
	logic signed [15:0] trig_s1;
	logic signed [15:0] win_s1;
	logic signed [15:0] v_s2, v_s3;
	logic signed [19:0] g_s3;
	logic [15:0]        sample_q;

	logic signed [31:0] prod;
	logic signed [31:0] rnd;
	logic signed [16:0] gain_x;
	logic signed [33:0] gp;
	logic signed [33:0] g;
	logic signed [19:0] off_x;
	logic signed [19:0] sum;

	always_comb begin
		adv      = !out_vld_q || m_tready;
		emit     = cur_vld_q && adv;
		last_smp = count_q == CNT_W'(SAMPLES_PER_SYMBOL - 1);
		q_pop    = q_nempty && (!cur_vld_q || (emit && last_smp));
		step     = cur_q.tone_low ? cfg.low_tone_step : cfg.carrier_step;
		// fsk tone is a cosine, a quarter turn ahead of the sine table
		ph       = cur_q.fsk ? (tone_q + 32'h4000_0000)
			: {acc_q[31] ^ cur_q.psk_bit, acc_q[30:0]};
		acc_adv  = (emit && !cur_q.fsk) ? acc_q + cfg.carrier_step : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			count_q   <= '0;
			tone_q    <= '0;
			acc_q     <= '0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				tone_q    <= '0;
				acc_q     <= q_head.clear_phase ? '0 : acc_adv;
			end else begin
				if (emit && last_smp) begin
					cur_vld_q <= 1'b0;
				end
				if (emit) begin
					tone_q <= tone_q + step;
				end
				acc_q <= acc_adv;
			end
			if (emit) begin
				count_q <= last_smp ? '0 : count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// window times tone, then fsk gain and offset
	always_comb begin
		prod   = 32'(win_s1) * 32'(trig_s1);
		rnd    = (prod + 32'sd16384) >>> 15;
		gain_x = $signed({1'b0, cfg.norm_gain});
		gp     = 34'(v_s2) * 34'(gain_x);
		g      = (gp + 34'sd8192) >>> 14;
		off_x  = 20'(cfg.norm_offset);
		sum    = g_s3 + off_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= emit;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s1  <= sine_f(ph);
			win_s1   <= $signed(WIN_TAB[count_q]);
			fsk_s1   <= cur_q.fsk;
			last_s1  <= last_smp;
			v_s2     <= sat16(rnd[19:0]);
			fsk_s2   <= fsk_s1;
			last_s2  <= last_s1;
			g_s3     <= g[19:0];
			v_s3     <= v_s2;
			fsk_s3   <= fsk_s2;
			last_s3  <= last_s2;
			sample_q <= fsk_s3 ? sat16(sum) : v_s3;
			last_q   <= last_s3;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = sample_q;
	assign m_tlast    = last_q;
	assign stat.emit  = emit;
	assign stat.busy  = cur_vld_q;
	assign stat.count = count_q;

endmodule

// ===== tb/windowed_tone_fsk_dpsk_modulator_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the windowed tone modulator, directed table then random symbols
module windowed_tone_fsk_dpsk_modulator_test;
	import wtfdm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_SYMBOLS  = 50;
	localparam int PRINT_CAP      = 32;
	localparam int N_ROWS         = 23;
	localparam int N_DIR_CFG      = 7;

	// hamming window 0.54 / 0.46 in q15
	localparam logic signed [63:0] HAM_A = 64'sd17695;
	localparam logic signed [63:0] HAM_B = 64'sd15073;

	// quarter wave polynomial in unsigned q30, highest order first for horner
	localparam logic [63:0] POLY [5] = '{64'd172272, 64'd5026995, 64'd85569306,
		64'd693598668, 64'd1686629713};

	// unused kind code, the block treats it as steady preamble
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [3:0]         cfg_no;
		logic               bit_value;
		logic [1:0]         kind;
		logic               sor;
		logic               fixed_on;   // every sample of the symbol is fixed_val
		logic signed [15:0] fixed_val;
	} sym_row_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               last;
	} tone_smp_t;

	// register settings of the directed part, entry 0 is the reset state
	localparam cfg_t DIR_CFG [N_DIR_CFG] = '{
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 16'd16384, 16'sd0},
		'{1'b0, 32'h0400_0000, 32'h0200_0000, 16'd16384, 16'sd0},
		'{1'b0, 32'hffff_ffff, 32'h8000_0000, 16'd0,     16'sh7fff},
		'{1'b0, 32'h0000_0001, 32'h4000_0000, 16'd0,     16'sh8000},
		'{1'b0, 32'h1000_0000, 32'hffff_ffff, 16'hffff,  16'sd0},
		'{1'b1, 32'h0400_0000, 32'hffff_ffff, 16'hffff,  16'sh7fff},
		'{1'b1, 32'hffff_ffff, 32'h0000_0000, 16'd0,     16'sh8000}
	};

	localparam sym_row_t PLAN [N_ROWS] = '{
		// reset settings: both tones at zero step, unity gain
		'{4'd0, 1'b0, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		'{4'd0, 1'b1, MODE_STEADY, 1'b1, 1'b0, 16'sd0},
		// fsk centre and low tone, kind is ignored
		'{4'd1, 1'b0, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		'{4'd1, 1'b1, MODE_ALT,    1'b0, 1'b0, 16'sd0},
		'{4'd1, 1'b1, KIND_SPARE,  1'b1, 1'b0, 16'sd0},
		// zero gain leaves only the offset
		'{4'd2, 1'b1, MODE_DATA,   1'b0, 1'b1, 16'sh7fff},
		'{4'd2, 1'b0, MODE_ALT,    1'b1, 1'b1, 16'sh7fff},
		'{4'd3, 1'b0, MODE_STEADY, 1'b0, 1'b1, 16'sh8000},
		'{4'd3, 1'b1, MODE_DATA,   1'b0, 1'b1, 16'sh8000},
		// maximum gain, saturation both ways
		'{4'd4, 1'b0, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		'{4'd4, 1'b1, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		// dbpsk: data, alternating, steady, spare kind and record restarts
		'{4'd5, 1'b1, MODE_DATA,   1'b1, 1'b0, 16'sd0},
		'{4'd5, 1'b0, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b1, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b0, MODE_ALT,    1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b1, MODE_ALT,    1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b1, MODE_STEADY, 1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b0, KIND_SPARE,  1'b0, 1'b0, 16'sd0},
		'{4'd5, 1'b0, MODE_ALT,    1'b1, 1'b0, 16'sd0},
		'{4'd5, 1'b1, MODE_DATA,   1'b0, 1'b0, 16'sd0},
		// carrier step of all ones
		'{4'd6, 1'b1, MODE_DATA,   1'b1, 1'b0, 16'sd0},
		'{4'd6, 1'b0, MODE_ALT,    1'b0, 1'b0, 16'sd0},
		'{4'd6, 1'b1, MODE_STEADY, 1'b0, 1'b0, 16'sd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic [2:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// predictor state and shadow of the registers
	cfg_t        shadow = DIR_CFG[0];
	logic [31:0] ph_acc = '0;
	logic        psk_bit = 1'b0;
	tone_smp_t   pending_samples [$];
	tone_smp_t   head;

	logic idle_on = 1'b1;
	int   ready_hold = 0;
	int   quiet_cycles = 0;
	int   mismatches = 0;
	int   samples_seen = 0;
	int   symbols_sent = 0;
	int   settings_used = 1;

	always #1 clk = ~clk;

	windowed_tone_fsk_dpsk_modulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// sin(pi/2 * k / quarter size) in q15
	function automatic logic signed [15:0] quarter_wave(input int unsigned k);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] p;
		u  = 64'(k) << (32 - SINE_TABLE_BITS);
		u2 = (u * u) >> 30;
		p  = POLY[0];
		for (int j = 1; j < 5; j++) begin
			p = POLY[j] - ((u2 * p) >> 30);
		end
		p = (((u * p) >> 30) + 64'd16384) >> 15;
		if (p > 64'd32767) begin
			p = 64'd32767;
		end
		return p[15:0];
	endfunction

	// table sine from the top phase bits, other quadrants mirrored
	function automatic logic signed [15:0] sine_of_phase(input logic [31:0] ph);
		logic [SINE_TABLE_BITS-1:0] idx;
		int unsigned                r;
		logic signed [15:0]         m;
		idx = ph[31 -: SINE_TABLE_BITS];
		r   = 32'(idx[SINE_TABLE_BITS-3:0]);
		if (idx[SINE_TABLE_BITS-2]) begin
			r = (1 << (SINE_TABLE_BITS - 2)) - r;
		end
		m = quarter_wave(r);
		return idx[SINE_TABLE_BITS-1] ? -m : m;
	endfunction

	function automatic logic signed [15:0] hamming_at(input int unsigned i);
		logic [63:0]        num;
		logic [31:0]        ph;
		logic signed [63:0] c;
		logic signed [63:0] t;
		num = 64'(i) << 32;
		ph  = 32'(num / 64'(SAMPLES_PER_SYMBOL - 1));
		c   = 64'(sine_of_phase(ph + 32'h4000_0000));
		t   = (HAM_B * c + 64'sd16384) >>> 15;
		return clamp16(HAM_A - t);
	endfunction

	// rounded q15 product, floor after the half bit
	function automatic logic signed [15:0] round_mul(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [63:0] x;
		x = 64'(a);
		x = x * 64'(b) + 64'sd16384;
		return clamp16(x >>> 15);
	endfunction

	// queues the 64 samples one accepted symbol must give
	task automatic predict_tone_samples(input logic bit_value, input logic [1:0] kind,
			input logic sor, input logic fixed_on, input logic signed [15:0] fixed_val);
		logic signed [15:0] w;
		logic signed [15:0] v;
		logic signed [15:0] y;
		logic signed [63:0] g;
		logic signed [63:0] gain;
		logic signed [63:0] off;
		logic [31:0]        inc;
		tone_smp_t          e;
		if (sor) begin
			ph_acc  = '0;
			psk_bit = 1'b0;
		end
		if (shadow.modulation) begin
			case (kind)
				MODE_DATA: begin
					psk_bit ^= bit_value;
				end
				MODE_ALT: begin
					psk_bit ^= 1'b1;
				end
				default: begin
					// steady preamble and spare code keep the phase bit
				end
			endcase
		end
		for (int n = 0; n < SAMPLES_PER_SYMBOL; n++) begin
			w = hamming_at(n);
			if (shadow.modulation) begin
				// kept phase bit adds half a turn, accumulator runs on across symbols
				y = round_mul(w, sine_of_phase(ph_acc + {psk_bit, 31'b0}));
				ph_acc += shadow.carrier_step;
			end else begin
				// fsk tone restarts at zero phase as a cosine
				inc  = bit_value ? shadow.low_tone_step : shadow.carrier_step;
				v    = round_mul(w, sine_of_phase(inc * 32'(n) + 32'h4000_0000));
				g    = 64'(v);
				gain = 64'(shadow.norm_gain);
				off  = 64'(shadow.norm_offset);
				g    = (g * gain + 64'sd8192) >>> 14;
				y    = clamp16(g + off);
			end
			if (fixed_on) begin
				y = fixed_val;
			end
			e.value = y;
			e.last  = (n == SAMPLES_PER_SYMBOL - 1);
			pending_samples = {pending_samples, e};
		end
	endtask

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("ERROR at %0t: %s", $time, what);
		end
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODULATION: begin
				shadow.modulation = value[0];
			end
			REG_CARRIER_STEP: begin
				shadow.carrier_step = value;
			end
			REG_LOW_TONE_STEP: begin
				shadow.low_tone_step = value;
			end
			REG_NORM_GAIN: begin
				shadow.norm_gain = value[15:0];
			end
			REG_NORM_OFFSET: begin
				shadow.norm_offset = value[15:0];
			end
			default: begin
			end
		endcase
	endtask

	// waits until every outstanding sample is out, then rewrites all registers
	task automatic load_settings(input cfg_t c);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		write_reg(REG_MODULATION, {31'b0, c.modulation});
		write_reg(REG_CARRIER_STEP, c.carrier_step);
		write_reg(REG_LOW_TONE_STEP, c.low_tone_step);
		write_reg(REG_NORM_GAIN, {16'b0, c.norm_gain});
		write_reg(REG_NORM_OFFSET, {16'b0, c.norm_offset});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_symbol(input logic bit_value, input logic [1:0] kind, input logic sor,
			input logic fixed_on, input logic signed [15:0] fixed_val);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, bit_value};
		s_tuser  <= {sor, kind};
		do @(posedge clk); while (!s_tready);
		predict_tone_samples(bit_value, kind, sor, fixed_on, fixed_val);
		symbols_sent++;
	endtask

	// slow tones half the time, else the extremes or any value
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: begin
				return 32'h0000_0000;
			end
			1: begin
				return 32'hffff_ffff;
			end
			2: begin
				return $urandom;
			end
			default: begin
				return $urandom_range(0, 32'h0800_0000);
			end
		endcase
	endfunction

	function automatic cfg_t pick_settings();
		cfg_t c;
		c.modulation    = 1'($urandom_range(0, 1));
		c.carrier_step  = pick_step();
		c.low_tone_step = pick_step();
		case ($urandom_range(0, 7))
			0: begin
				c.norm_gain = 16'h0000;
			end
			1: begin
				c.norm_gain = 16'hffff;
			end
			2: begin
				c.norm_gain = 16'($urandom);
			end
			default: begin
				c.norm_gain = 16'($urandom_range(8192, 24576));
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			c.norm_offset = 16'($urandom);
		end else begin
			c.norm_offset = 16'($urandom_range(0, 8191) - 4096);
		end
		return c;
	endfunction

	// random symbol, mostly data with runs of preamble, sometimes a new record
	task automatic send_random_symbol();
		logic [1:0] kind;
		int         r;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			kind = MODE_DATA;
		end else if (r < 16) begin
			kind = MODE_ALT;
		end else if (r < 19) begin
			kind = MODE_STEADY;
		end else begin
			kind = KIND_SPARE;
		end
		send_symbol(1'($urandom_range(0, 1)), kind, $urandom_range(0, 9) == 0, 1'b0, 16'sd0);
	endtask

	// sample checker and output stall bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			samples_seen++;
			if (pending_samples.size() == 0) begin
				flag_mismatch($sformatf("sample item %0d with nothing outstanding", samples_seen));
			end else begin
				head = pending_samples.pop_front();
				if (m_tdata !== head.value) begin
					flag_mismatch($sformatf("sample item %0d: value %0d, expected %0d",
						samples_seen, $signed(m_tdata), head.value));
				end
				if (m_tlast !== head.last) begin
					flag_mismatch($sformatf("sample item %0d: last %b, expected %b",
						samples_seen, m_tlast, head.last));
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 3);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// cycles since the last handshake on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("timeout: no handshake for %0d cycles, %0d samples outstanding",
			WATCHDOG_LIMIT, pending_samples.size());
		$display("windowed_tone_fsk_dpsk_modulator: mismatch");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, registers rewritten whenever the row asks for another setting
		for (int r = 0; r < N_ROWS; r++) begin
			if (r > 0 && PLAN[r].cfg_no != PLAN[r-1].cfg_no) begin
				load_settings(DIR_CFG[PLAN[r].cfg_no]);
			end
			send_symbol(PLAN[r].bit_value, PLAN[r].kind, PLAN[r].sor, PLAN[r].fixed_on,
				PLAN[r].fixed_val);
		end

		// random settings, the last phase runs without idling
		for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			load_settings(pick_settings());
			idle_on = (phase_no < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_SYMBOLS; k++) begin
				send_random_symbol();
			end
		end

		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d symbols over %0d register settings, %0d samples checked",
			symbols_sent, settings_used, samples_seen);
		if (mismatches == 0) begin
			$display("windowed_tone_fsk_dpsk_modulator: match");
		end else begin
			$display("%0d field mismatches", mismatches);
			$display("windowed_tone_fsk_dpsk_modulator: mismatch");
		end
		$finish;
	end

endmodule
